[rtl/gtuc_pkg.sv]
// shared widths, constants and types for the gps time to utc calendar core
package gtuc_pkg;

  localparam int WEEK_W  = 14;
  localparam int SECS_W  = 20;
  localparam int LEAP_W  = 6;
  localparam int YEAR_W  = 8;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;

  localparam logic [LEAP_W-1:0] LEAP_RESET = 6'd18;

  localparam int SEC_PER_DAY = 86400;
  localparam int WEEK_MAX    = 2 ** WEEK_W - 1;
  localparam int SECS_MAX    = 2 ** SECS_W - 1;
  localparam int DAY_Q_MAX   = SECS_MAX / SEC_PER_DAY;
  localparam int CNT_W       = $clog2(DAY_Q_MAX + 1);
  localparam int Q_W         = CNT_W + 1;
  localparam int S_W         = SECS_W + 1;
  localparam int SOD_W       = $clog2(SEC_PER_DAY);

  localparam int FVF_OFFSET  = 68569;

  localparam int STAGES  = 8;
  localparam int ST_IN   = 0;
  localparam int ST_DAY  = 1;
  localparam int ST_DIV  = 2;
  localparam int ST_REM  = 3;
  localparam int ST_YEAR = 4;
  localparam int ST_L3   = 5;
  localparam int ST_MON  = 6;
  localparam int ST_OUT  = 7;

  typedef logic [STAGES-1:0] stage_en_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } hms_t;

endpackage

[rtl/gtuc_split.sv]
// leap second removal and split into fvf day operand and seconds of day
module gtuc_split import gtuc_pkg::*; #(
  parameter int EPOCH_DAY_NUMBER = 2444245,
  parameter int L_W = 22
) (
  input  logic              clk,
  input  stage_en_t         en,
  input  logic [WEEK_W-1:0] week_number,
  input  logic [SECS_W-1:0] week_seconds,
  input  logic [LEAP_W-1:0] leap,
  output logic [L_W-1:0]    l1,
  output logic [SOD_W-1:0]  sod
);

  logic [WEEK_W-1:0]        week1;
  logic signed [S_W-1:0]    s1;
  logic signed [Q_W-1:0]    q1;

  logic signed [S_W-1:0]    s_next;
  logic [CNT_W-1:0]         cnt;
  logic signed [Q_W-1:0]    q_next;

  logic [L_W-1:0]           wk;
  logic [L_W-1:0]           q_l;
  logic [L_W-1:0]           l1_next;
  logic signed [S_W-1:0]    q_s;
  logic signed [S_W-1:0]    sod_full;

  always_comb begin
    s_next = $signed({1'b0, week_seconds}) - $signed({{(S_W-LEAP_W){1'b0}}, leap});
    cnt = '0;
    for (int k = 1; k <= DAY_Q_MAX; k++) begin
      if (s_next >= $signed(S_W'(k * SEC_PER_DAY))) begin
        cnt = cnt + CNT_W'(1);
      end
    end
    q_next = s_next[S_W-1] ? '1 : $signed({1'b0, cnt});
  end

  always_ff @(posedge clk) begin
    if (en[ST_IN]) begin
      week1 <= week_number;
      s1    <= s_next;
      q1    <= q_next;
    end
  end

  always_comb begin
    wk       = L_W'(week1);
    q_l      = {{(L_W-Q_W){q1[Q_W-1]}}, q1};
    l1_next  = (wk << 3) - wk + q_l + L_W'(EPOCH_DAY_NUMBER + FVF_OFFSET);
    q_s      = S_W'(q1);
    sod_full = s1 - q_s * $signed(S_W'(SEC_PER_DAY));
  end

  always_ff @(posedge clk) begin
    if (en[ST_DAY]) begin
      l1  <= l1_next;
      sod <= sod_full[SOD_W-1:0];
    end
  end

endmodule

[rtl/gtuc_tod.sv]
// time of day pipeline: hour, minute and second from seconds of day
module gtuc_tod import gtuc_pkg::*; (
  input  logic             clk,
  input  stage_en_t        en,
  input  logic [SOD_W-1:0] sod,
  output hms_t             hms
);

  localparam int MT_W   = 11;
  localparam int S_H    = SOD_W + 12;
  localparam longint M_H = ((64'd1 << S_H) + 64'd3599) / 64'd3600;
  localparam int M_H_W  = $clog2(M_H + 1);
  localparam int PH_W   = SOD_W + M_H_W + 1;
  localparam int S_MT   = SOD_W + 6;
  localparam longint M_MT = ((64'd1 << S_MT) + 64'd59) / 64'd60;
  localparam int M_MT_W = $clog2(M_MT + 1);
  localparam int PM_W   = SOD_W + M_MT_W + 1;
  localparam int DELAY  = ST_OUT - ST_REM;

  logic [PH_W-1:0]   h_prod;
  logic [PM_W-1:0]   m_prod;

  logic [HOUR_W-1:0] hour3;
  logic [MT_W-1:0]   mt3;
  logic [SOD_W-1:0]  sod3;

  hms_t              hms_next;
  hms_t              st4;
  hms_t              pipe [DELAY];

  assign h_prod = PH_W'(sod) * PH_W'(M_H);
  assign m_prod = PM_W'(sod) * PM_W'(M_MT);

  always_ff @(posedge clk) begin
    if (en[ST_DIV]) begin
      hour3 <= h_prod[S_H +: HOUR_W];
      mt3   <= m_prod[S_MT +: MT_W];
      sod3  <= sod;
    end
  end

  always_comb begin
    hms_next.hour   = hour3;
    hms_next.minute = MIN_W'(mt3 - MT_W'(60 * 32'(hour3)));
    hms_next.second = SEC_W'(sod3 - SOD_W'(60 * 32'(mt3)));
  end

  always_ff @(posedge clk) begin
    if (en[ST_REM]) begin
      st4 <= hms_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DELAY; i++) begin
      if (en[ST_YEAR + i]) begin
        pipe[i] <= (i == 0) ? st4 : pipe[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign hms = pipe[DELAY-1];

endmodule

[rtl/gtuc_date.sv]
// fliegel-van flandern date pipeline from the offset julian day number
module gtuc_date import gtuc_pkg::*; #(
  parameter int L_W = 22
) (
  input  logic               clk,
  input  stage_en_t          en,
  input  logic [L_W-1:0]     l1,
  output logic [YEAR_W-1:0]  year_offset,
  output logic [MONTH_W-1:0] month,
  output logic [DAY_W-1:0]   day_of_month
);

  localparam int FVF_CYCLE    = 146097;
  localparam int YEAR_CYCLE   = 1461;
  localparam int MONTH_BASE   = 31;
  localparam int YEAR_SCALE   = 100;
  localparam int CENTURY_BIAS = 6900;
  localparam int MONTH_WRAP   = 11;

  localparam int N_MAX = (4 * (2 ** L_W - 1)) / FVF_CYCLE;
  localparam int N_W   = $clog2(N_MAX + 1);
  localparam int L2_W  = 16;
  localparam int L3_W  = 9;
  localparam int YR_W  = 7;
  localparam int MO_W  = 4;
  localparam int DS_W  = 9;
  localparam int YQ_W  = 18;

  localparam int S_N      = L_W + $clog2(FVF_CYCLE);
  localparam longint M_N  = ((64'd4 << S_N) + 64'd146096) / 64'd146097;
  localparam int M_N_W    = $clog2(M_N + 1);
  localparam int PN_W     = L_W + M_N_W + 1;

  localparam int S_Y      = L2_W + 1 + 21;
  localparam longint M_Y  = ((64'd4000 << S_Y) + 64'd1461000) / 64'd1461001;
  localparam int M_Y_W    = $clog2(M_Y + 1);
  localparam int PY_W     = L2_W + 1 + M_Y_W + 1;

  localparam int S_M      = L3_W + 12;
  localparam longint M_M  = ((64'd80 << S_M) + 64'd2446) / 64'd2447;
  localparam int M_M_W    = $clog2(M_M + 1);
  localparam int PM_W     = L3_W + M_M_W + 1;

  localparam int S_D      = MO_W + 7;
  localparam longint M_D  = ((64'd2447 << S_D) + 64'd79) / 64'd80;
  localparam int M_D_W    = $clog2(M_D + 1);
  localparam int PD_W     = MO_W + M_D_W + 1;

  logic [PN_W-1:0] n_prod;
  logic [N_W-1:0]  n3;
  logic [L_W-1:0]  l1_3;

  logic [L_W-1:0]  cyc_q;
  logic [L2_W-1:0] l2_4;
  logic [N_W-1:0]  n4;

  logic [PY_W-1:0] y_prod;
  logic [YR_W-1:0] yr5;
  logic [L2_W-1:0] l2_5;
  logic [N_W-1:0]  n5;

  logic [YQ_W-1:0] yq;
  logic [L3_W-1:0] l3_6;
  logic [YR_W-1:0] yr6;
  logic [N_W-1:0]  n6;

  logic [PM_W-1:0] m_prod;
  logic [MO_W-1:0] mo7;
  logic [L3_W-1:0] l3_7;
  logic [YR_W-1:0] yr7;
  logic [N_W-1:0]  n7;

  logic [PD_W-1:0] d_prod;
  logic            k;
  logic [15:0]     year_full;

  assign n_prod = PN_W'(l1) * PN_W'(M_N);

  always_ff @(posedge clk) begin
    if (en[ST_DIV]) begin
      n3   <= n_prod[S_N +: N_W];
      l1_3 <= l1;
    end
  end

  assign cyc_q = L_W'((FVF_CYCLE * 32'(n3) + 3) >> 2);

  always_ff @(posedge clk) begin
    if (en[ST_REM]) begin
      l2_4 <= L2_W'(l1_3 - cyc_q);
      n4   <= n3;
    end
  end

  assign y_prod = PY_W'(l2_4 + L2_W'(1)) * PY_W'(M_Y);

  always_ff @(posedge clk) begin
    if (en[ST_YEAR]) begin
      yr5  <= y_prod[S_Y +: YR_W];
      l2_5 <= l2_4;
      n5   <= n4;
    end
  end

  assign yq = YQ_W'((YEAR_CYCLE * 32'(yr5)) >> 2);

  always_ff @(posedge clk) begin
    if (en[ST_L3]) begin
      l3_6 <= L3_W'(YQ_W'(l2_5) - yq + YQ_W'(MONTH_BASE));
      yr6  <= yr5;
      n6   <= n5;
    end
  end

  assign m_prod = PM_W'(l3_6) * PM_W'(M_M);

  always_ff @(posedge clk) begin
    if (en[ST_MON]) begin
      mo7  <= m_prod[S_M +: MO_W];
      l3_7 <= l3_6;
      yr7  <= yr6;
      n7   <= n6;
    end
  end

  always_comb begin
    d_prod    = PD_W'(mo7) * PD_W'(M_D);
    k         = (mo7 >= MO_W'(MONTH_WRAP));
    year_full = 16'(YEAR_SCALE * 32'(n7)) + 16'(yr7) + 16'(k) - 16'(CENTURY_BIAS);
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      day_of_month <= DAY_W'(l3_7 - L3_W'(d_prod[S_D +: DS_W]));
      month        <= k ? MONTH_W'(mo7 + MO_W'(2) - MO_W'(12)) : MONTH_W'(mo7 + MO_W'(2));
      year_offset  <= year_full[YEAR_W-1:0];
    end
  end

endmodule

[rtl/gps_time_to_utc_calendar_core.sv]
// top level of the gps week and seconds to utc calendar converter
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   week_number, week_seconds
//   out      output     out_valid / out_stall year_offset, month, day_of_month,
//                                             hour, minute, second
//   cfg      input      cfg_wen               cfg_wdata (leap seconds)
//
// eight register stages: one transaction can be accepted every cycle while
// in_stall is low, that is, unless all stages are full and out is stalled.
// the depth is set by the chain of constant divisions in the date path, done as
// reciprocal multiplies.
// reset clears all stage valid bits and loads leap seconds with 18.
// a stall on out backs up only the full stages; empty stages keep filling, and
// in_stall rises when all eight stages hold data and out is stalled.
module gps_time_to_utc_calendar_core import gtuc_pkg::*; #(
  parameter int EPOCH_DAY_NUMBER = 2444245
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [WEEK_W-1:0]  week_number,
  input  logic [SECS_W-1:0]  week_seconds,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [YEAR_W-1:0]  year_offset,
  output logic [MONTH_W-1:0] month,
  output logic [DAY_W-1:0]   day_of_month,
  output logic [HOUR_W-1:0]  hour,
  output logic [MIN_W-1:0]   minute,
  output logic [SEC_W-1:0]   second,
  input  logic               cfg_wen,
  input  logic [LEAP_W-1:0]  cfg_wdata
);

  localparam int L_MAX = EPOCH_DAY_NUMBER + WEEK_MAX * 7 + DAY_Q_MAX + FVF_OFFSET;
  localparam int L_W   = $clog2(L_MAX + 1);

  logic [LEAP_W-1:0] leap;
  logic [STAGES-1:0] v;
  stage_en_t         en;
  logic [L_W-1:0]    l1;
  logic [SOD_W-1:0]  sod;
  hms_t              hms;

  always_ff @(posedge clk) begin
    if (rst) begin
      leap <= LEAP_RESET;
    end else if (cfg_wen) begin
      leap <= cfg_wdata;
    end
  end

  always_comb begin
    en[STAGES-1] = !v[STAGES-1] || !out_stall;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < STAGES; i++) begin
        if (en[i]) begin
          v[i] <= (i == 0) ? in_valid : v[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign in_stall  = !en[ST_IN];
  assign out_valid = v[ST_OUT];

  gtuc_split #(
    .EPOCH_DAY_NUMBER(EPOCH_DAY_NUMBER),
    .L_W(L_W)
  ) u_split (
    .clk(clk),
    .en(en),
    .week_number(week_number),
    .week_seconds(week_seconds),
    .leap(leap),
    .l1(l1),
    .sod(sod)
  );

  gtuc_tod u_tod (
    .clk(clk),
    .en(en),
    .sod(sod),
    .hms(hms)
  );

  gtuc_date #(
    .L_W(L_W)
  ) u_date (
    .clk(clk),
    .en(en),
    .l1(l1),
    .year_offset(year_offset),
    .month(month),
    .day_of_month(day_of_month)
  );

  assign hour   = hms.hour;
  assign minute = hms.minute;
  assign second = hms.second;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high right after reset");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> ($countones(v) == STAGES) && out_stall)
    else $error("input stalled while the pipeline has room");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month >= 4'd1) && (month <= 4'd12) && (day_of_month >= 5'd1))
    else $error("calendar date out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59))
    else $error("time of day out of range");

endmodule
